@@ design/csspg_pkg.sv @@
// Package for the cyclic slew-limited step profile generator.
// Holds widths, register indexes and reset values; no dependencies.
package csspg_pkg;

    localparam int MAX_CYCLE_SAMPLES = 4096;
    localparam int LEVEL_W           = 16;
    localparam int LEN_W             = 13;
    localparam int POS_W             = 12;
    localparam int CYC_W             = 16;
    localparam int IDX_W             = 24;
    localparam int SLEW_W            = 16;
    localparam int AMP_W             = 15;

    // Divider: 28-bit dividend covers |i * delta| < 2^28, 16-bit divisor.
    localparam int DIV_W  = 28;
    localparam int REM_W  = 16;
    localparam int CNT_W  = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CYCLE_LENGTH    = 3'd0,
        REG_CYCLE_TOTAL     = 3'd1,
        REG_SAMPLE_TOTAL    = 3'd2,
        REG_SLEW_PER_SAMPLE = 3'd3,
        REG_LEVEL_LIMIT     = 3'd4,
        REG_INVERT          = 3'd5
    } cfg_reg_t;

    localparam logic [LEN_W-1:0]  RST_CYCLE_LENGTH    = 13'd1000;
    localparam logic [CYC_W-1:0]  RST_CYCLE_TOTAL     = 16'd10;
    localparam logic [IDX_W-1:0]  RST_SAMPLE_TOTAL    = 24'd10000;
    localparam logic [SLEW_W-1:0] RST_SLEW_PER_SAMPLE = 16'd64;
    localparam logic [AMP_W-1:0]  RST_LEVEL_LIMIT     = 15'd32767;

    localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(MAX_CYCLE_SAMPLES);

endpackage

@@ design/cyclic_slew_step_profile_gen.sv @@
// Cyclic slew-limited step profile generator, top level; needs csspg_pkg.
// A tick goes ST_CHECK then ST_OUT when held, finished or past the cycles; via ST_MUL
// on a flat sample; via ST_MUL and one 28-step shared divide (ST_DIV_SAMP) on a ramp
// sample; at a cycle start with nonzero slew a 28-step divide (ST_DIV_RAMP) first finds
// the ramp length. One tick at a time; in_ready is high in the cycle result valid rises.
// Reset (rst_n low, asynchronous) loads register defaults and clears all state.
module cyclic_slew_step_profile_gen (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [csspg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csspg_pkg::CFG_DATA_W-1:0]      cfg_data,
    // tick input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  restart,
    input  logic signed [csspg_pkg::LEVEL_W-1:0]  target_amplitude,
    // sample output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [csspg_pkg::LEVEL_W-1:0]  setpoint,
    output logic                                  finished
);
    import csspg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_RAMP,
        ST_MUL,
        ST_DIV_SAMP,
        ST_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers; writes must arrive only while the block is idle
    // (the block itself does not enforce this); the port is always ready.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  cycle_length_reg;
    logic [CYC_W-1:0]  cycle_total_reg;
    logic [IDX_W-1:0]  sample_total_reg;
    logic [SLEW_W-1:0] slew_reg;
    logic [AMP_W-1:0]  level_lim_reg;
    logic              invert_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_length_reg <= RST_CYCLE_LENGTH;
            cycle_total_reg  <= RST_CYCLE_TOTAL;
            sample_total_reg <= RST_SAMPLE_TOTAL;
            slew_reg         <= RST_SLEW_PER_SAMPLE;
            level_lim_reg    <= RST_LEVEL_LIMIT;
            invert_reg       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CYCLE_LENGTH:    cycle_length_reg <= cfg_data[LEN_W-1:0];
                REG_CYCLE_TOTAL:     cycle_total_reg  <= cfg_data[CYC_W-1:0];
                REG_SAMPLE_TOTAL:    sample_total_reg <= cfg_data[IDX_W-1:0];
                REG_SLEW_PER_SAMPLE: slew_reg         <= cfg_data[SLEW_W-1:0];
                REG_LEVEL_LIMIT:     level_lim_reg    <= cfg_data[AMP_W-1:0];
                REG_INVERT:          invert_reg       <= cfg_data[0];
                default:             ; // unused indexes: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state, trajectory state and the shared divider
    // ------------------------------------------------------------------
    state_t                     state_reg,     state_next;
    logic signed [LEVEL_W-1:0]  target_reg,    target_next;
    logic [IDX_W-1:0]           sidx_reg,      sidx_next;
    logic [POS_W-1:0]           pos_reg,       pos_next;
    logic [CYC_W-1:0]           cnum_reg,      cnum_next;
    logic signed [LEVEL_W-1:0]  cur_reg,       cur_next;
    logic signed [LEVEL_W-1:0]  nxt_reg,       nxt_next;
    logic [LEN_W-1:0]           ramp_reg,      ramp_next;
    logic signed [LEVEL_W-1:0]  last_reg,      last_next;
    logic signed [LEVEL_W-1:0]  sample_reg,    sample_next;
    logic                       fin_reg,       fin_next;
    logic                       active_reg,    active_next;
    logic                       neg_reg,       neg_next;
    logic [DIV_W-1:0]           quo_reg,       quo_next;
    logic [REM_W-1:0]           rem_reg,       rem_next;
    logic [REM_W-1:0]           divisor_reg,   divisor_next;
    logic [CNT_W-1:0]           cnt_reg,       cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [LEVEL_W-1:0]  setpoint_reg,  setpoint_next;
    logic                       finished_reg,  finished_next;

    // Effective cycle length: zero acts as one, clamp to the maximum.
    logic [LEN_W-1:0] len_w;
    logic [LEN_W-1:0] len_m1;
    logic [POS_W-1:0] pos_c;

    always_comb
    begin
        if (cycle_length_reg == '0)
            len_w = LEN_W'(1);
        else if (cycle_length_reg > LEN_MAX)
            len_w = LEN_MAX;
        else
            len_w = cycle_length_reg;
        len_m1 = len_w - LEN_W'(1);
        // Saturate a stale position after the cycle length shrank.
        if ({1'b0, pos_reg} >= len_w)
            pos_c = len_m1[POS_W-1:0];
        else
            pos_c = pos_reg;
    end

    // New level at cycle start: clamp to +/- the level limit, force zero in the
    // first cycle and the last two.
    logic signed [LEVEL_W:0]    tgt_ext;
    logic signed [LEVEL_W:0]    lim_ext;
    logic signed [LEVEL_W:0]    tgt_clamped;
    logic                       force_zero;
    logic signed [LEVEL_W:0]    tgt_diff;
    logic [LEVEL_W-1:0]         tgt_mag;

    always_comb
    begin
        tgt_ext = {target_reg[LEVEL_W-1], target_reg};
        lim_ext = {2'b00, level_lim_reg};
        if (tgt_ext > lim_ext)
            tgt_clamped = lim_ext;
        else if (tgt_ext < -lim_ext)
            tgt_clamped = -lim_ext;
        else
            tgt_clamped = tgt_ext;
        force_zero = (cnum_reg == '0) ||
                     (({1'b0, cnum_reg} + (CYC_W+1)'(2)) >= {1'b0, cycle_total_reg});
        if (force_zero)
            tgt_clamped = '0;
        tgt_diff = tgt_clamped - {cur_reg[LEVEL_W-1], cur_reg};
        if (tgt_diff < 0)
            tgt_diff = -tgt_diff;
        tgt_mag = tgt_diff[LEVEL_W-1:0];
    end

    // Ramp geometry and the single multiplier i * delta.
    logic [LEN_W-1:0]           rl_c;
    logic [LEN_W-1:0]           stat_w;
    logic [LEN_W-1:0]           ramp_i_w;
    logic signed [LEVEL_W:0]    delta_w;
    logic signed [LEN_W+LEVEL_W:0] prod_w;
    logic signed [LEN_W+LEVEL_W:0] prod_abs;

    always_comb
    begin
        if (ramp_reg == '0)
            rl_c = LEN_W'(1);
        else if (ramp_reg > len_w)
            rl_c = len_w;
        else
            rl_c = ramp_reg;
        stat_w   = len_w - rl_c;
        ramp_i_w = {1'b0, pos_reg} - stat_w;
        delta_w  = {nxt_reg[LEVEL_W-1], nxt_reg} - {cur_reg[LEVEL_W-1], cur_reg};
        prod_w   = $signed({1'b0, ramp_i_w[POS_W-1:0]}) * delta_w;
        prod_abs = prod_w[LEN_W+LEVEL_W] ? -prod_w : prod_w;
    end

    // One restoring step of the shared divider.
    logic [REM_W:0]   div_shift;
    logic             div_ge;
    logic [REM_W:0]   div_diff;
    logic [DIV_W-1:0] quo_step;
    logic [REM_W-1:0] rem_step;

    always_comb
    begin
        div_shift = {rem_reg, quo_reg[DIV_W-1]};
        div_ge    = div_shift >= {1'b0, divisor_reg};
        div_diff  = div_shift - {1'b0, divisor_reg};
        quo_step  = {quo_reg[DIV_W-2:0], div_ge};
        rem_step  = div_ge ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];
    end

    // Quotient uses: ramp length and the signed ramp sample.
    logic [LEVEL_W:0]          ramp_p1;
    logic signed [LEVEL_W+1:0] q_signed;
    logic signed [LEVEL_W+1:0] ramp_sum;
    logic [LEN_W-1:0]          pos_p1;

    always_comb
    begin
        ramp_p1  = quo_step[LEVEL_W:0] + (LEVEL_W+1)'(1);
        q_signed = $signed({1'b0, quo_step[LEVEL_W:0]});
        if (neg_reg)
            q_signed = -q_signed;
        ramp_sum = {{2{cur_reg[LEVEL_W-1]}}, cur_reg} + q_signed;
        pos_p1   = {1'b0, pos_reg} + LEN_W'(1);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign setpoint  = setpoint_reg;
    assign finished  = finished_reg;

    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        sidx_next      = sidx_reg;
        pos_next       = pos_reg;
        cnum_next      = cnum_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        ramp_next      = ramp_reg;
        last_next      = last_reg;
        sample_next    = sample_reg;
        fin_next       = fin_reg;
        active_next    = active_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        setpoint_next  = setpoint_reg;
        finished_next  = finished_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    target_next = target_amplitude;
                    // Restart clears the trajectory before this tick is handled.
                    if (restart)
                    begin
                        sidx_next = '0;
                        pos_next  = '0;
                        cnum_next = '0;
                        cur_next  = '0;
                        nxt_next  = '0;
                        ramp_next = LEN_W'(1);
                        last_next = '0;
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (sidx_reg >= sample_total_reg)
                begin
                    // Past the trajectory: hold the last sample, change nothing.
                    sample_next = last_reg;
                    fin_next    = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    fin_next = 1'b0;
                    pos_next = pos_c;
                    if (cnum_reg < cycle_total_reg)
                    begin
                        active_next = 1'b1;
                        if (pos_c == '0)
                        begin
                            nxt_next = tgt_clamped[LEVEL_W-1:0];
                            if (slew_reg == '0)
                            begin
                                ramp_next  = len_w;
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                quo_next     = DIV_W'(tgt_mag);
                                rem_next     = '0;
                                divisor_next = slew_reg;
                                cnt_next     = CNT_W'(DIV_W - 1);
                                state_next   = ST_DIV_RAMP;
                            end
                        end
                        else
                        begin
                            state_next = ST_MUL;
                        end
                    end
                    else
                    begin
                        // Past the last cycle: output zero.
                        active_next = 1'b0;
                        sample_next = '0;
                        state_next  = ST_OUT;
                    end
                end
            end

            ST_DIV_RAMP:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    // Ramp length = quotient + 1, clamped to the cycle length.
                    if (ramp_p1 > {{(LEVEL_W+1-LEN_W){1'b0}}, len_w})
                        ramp_next = len_w;
                    else
                        ramp_next = ramp_p1[LEN_W-1:0];
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if ({1'b0, pos_reg} < stat_w)
                begin
                    sample_next = cur_reg;
                    state_next  = ST_OUT;
                end
                else
                begin
                    neg_next     = prod_w[LEN_W+LEVEL_W];
                    quo_next     = prod_abs[DIV_W-1:0];
                    rem_next     = '0;
                    divisor_next = REM_W'(rl_c);
                    cnt_next     = CNT_W'(DIV_W - 1);
                    state_next   = ST_DIV_SAMP;
                end
            end

            ST_DIV_SAMP:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    sample_next = ramp_sum[LEVEL_W-1:0];
                    state_next  = ST_OUT;
                end
            end

            ST_OUT:
            begin
                // Wait for the output register to free up, then transfer.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    setpoint_next  = invert_reg ? -sample_reg : sample_reg;
                    finished_next  = fin_reg;
                    if (!fin_reg)
                    begin
                        last_next = sample_reg;
                        sidx_next = sidx_reg + IDX_W'(1);
                        if (active_reg)
                        begin
                            // Advance the position; at cycle end take the new level.
                            if (pos_p1 >= len_w)
                            begin
                                pos_next = '0;
                                cur_next = nxt_reg;
                                if (cnum_reg != '1)
                                    cnum_next = cnum_reg + CYC_W'(1);
                            end
                            else
                            begin
                                pos_next = pos_p1[POS_W-1:0];
                            end
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            sidx_reg      <= '0;
            pos_reg       <= '0;
            cnum_reg      <= '0;
            cur_reg       <= '0;
            nxt_reg       <= '0;
            ramp_reg      <= LEN_W'(1);
            last_reg      <= '0;
            sample_reg    <= '0;
            fin_reg       <= 1'b0;
            active_reg    <= 1'b0;
            neg_reg       <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            divisor_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            setpoint_reg  <= '0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            sidx_reg      <= sidx_next;
            pos_reg       <= pos_next;
            cnum_reg      <= cnum_next;
            cur_reg       <= cur_next;
            nxt_reg       <= nxt_next;
            ramp_reg      <= ramp_next;
            last_reg      <= last_next;
            sample_reg    <= sample_next;
            fin_reg       <= fin_next;
            active_reg    <= active_next;
            neg_reg       <= neg_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            divisor_reg   <= divisor_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            setpoint_reg  <= setpoint_next;
            finished_reg  <= finished_next;
        end
    end

endmodule
